### hdl/tpi_pkg.sv
// Shared types, codes and small lookup functions for the triangle pair test.
// Used by every module of the block; depends on nothing.
package tpi_pkg;

	localparam int COORD_WIDTH_DEF = 24;
	localparam int NUM_VERT = 6;
	localparam int AXIS_IDX_W = 4;

	localparam logic [AXIS_IDX_W-1:0] AXIS_N1   = 4'd0;
	localparam logic [AXIS_IDX_W-1:0] AXIS_N2   = 4'd1;
	localparam logic [AXIS_IDX_W-1:0] AXIS_LAST = 4'd10;

	localparam logic [2:0] STEP_LAST = 3'd5;

	localparam logic REQ_STORE = 1'b0;
	localparam logic REQ_TEST  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUB,
		ST_PROJ,
		ST_DRAIN,
		ST_MINMAX,
		ST_CMP,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic mul;
		logic sub;
	} gen_ctrl_t;

	typedef struct packed {
		logic clr;
		logic en;
		logic high;
	} lane_ctrl_t;

	// Edge cross-product axes: returns {edge of first triangle, edge of second}.
	function automatic logic [3:0] edge_pair(input logic [AXIS_IDX_W-1:0] idx);
		logic [3:0] r;
		case (idx)
			4'd2:    r = {2'd0, 2'd0};
			4'd3:    r = {2'd0, 2'd1};
			4'd4:    r = {2'd0, 2'd2};
			4'd5:    r = {2'd1, 2'd0};
			4'd6:    r = {2'd1, 2'd1};
			4'd7:    r = {2'd1, 2'd2};
			4'd8:    r = {2'd2, 2'd0};
			4'd9:    r = {2'd2, 2'd1};
			4'd10:   r = {2'd2, 2'd2};
			default: r = 4'd0;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] next_vert(input logic [1:0] v);
		logic [1:0] r;
		case (v)
			2'd0:    r = 2'd1;
			2'd1:    r = 2'd2;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

endpackage

### hdl/tpi_axis_gen.sv
// Candidate axis generator: picks a pair of edge vectors and forms their cross product.
// Depends on tpi_pkg for the axis codes and the edge lookup.
module tpi_axis_gen #(
	parameter int W = tpi_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  tpi_pkg::gen_ctrl_t            ctrl,
	input  logic [tpi_pkg::AXIS_IDX_W-1:0] idx,
	input  logic signed [W-1:0]           t1[3][3],
	input  logic signed [W-1:0]           t2[3][3],
	output logic signed [2*W+2:0]         axis_q[3],
	output logic                          zero_q
);

	localparam int EW = W + 1;
	localparam int PW = 2 * EW;
	localparam int AW = 2 * W + 3;

	logic [3:0] pair;
	logic [1:0] ei, ej;
	logic signed [EW-1:0] u[3];
	logic signed [EW-1:0] v[3];
	logic signed [PW-1:0] prod_s1[3][2];
	logic signed [AW-1:0] diff[3];

	assign pair = tpi_pkg::edge_pair(idx);
	assign ei = pair[3:2];
	assign ej = pair[1:0];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			case (idx)
				tpi_pkg::AXIS_N1: begin
					u[k] = EW'(t1[1][k]) - EW'(t1[0][k]);
					v[k] = EW'(t1[2][k]) - EW'(t1[0][k]);
				end
				tpi_pkg::AXIS_N2: begin
					u[k] = EW'(t2[1][k]) - EW'(t2[0][k]);
					v[k] = EW'(t2[2][k]) - EW'(t2[0][k]);
				end
				default: begin
					u[k] = EW'(t1[tpi_pkg::next_vert(ei)][k]) - EW'(t1[ei][k]);
					v[k] = EW'(t2[tpi_pkg::next_vert(ej)][k]) - EW'(t2[ej][k]);
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.mul) begin
			for (int k = 0; k < 3; k++) begin
				prod_s1[k][0] <= PW'(u[(k + 1) % 3]) * PW'(v[(k + 2) % 3]);
				prod_s1[k][1] <= PW'(u[(k + 2) % 3]) * PW'(v[(k + 1) % 3]);
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++)
			diff[k] = AW'(prod_s1[k][0]) - AW'(prod_s1[k][1]);
	end

	always_ff @(posedge clk) begin
		if (ctrl.sub) begin
			for (int k = 0; k < 3; k++)
				axis_q[k] <= diff[k];
			zero_q <= (diff[0] == '0) && (diff[1] == '0) && (diff[2] == '0);
		end
	end

endmodule

### hdl/tpi_proj_lane.sv
// One projection lane: accumulates the dot product of the axis with one vertex,
// one axis half-component per cycle. Depends on tpi_pkg for the lane controls.
module tpi_proj_lane #(
	parameter int W = tpi_pkg::COORD_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tpi_pkg::lane_ctrl_t             ctrl,
	input  logic signed [(2*W+4)/2:0]       a,
	input  logic signed [W:0]               b,
	output logic signed [3*W+5:0]           acc_q
);

	localparam int EW = W + 1;
	localparam int AW = 2 * W + 3;
	localparam int LW = (AW + 1) / 2;
	localparam int MW = LW + 1;
	localparam int SW = AW + EW + 2;

	logic signed [MW+EW-1:0] prod_s1;
	logic                    high_s1;
	logic                    en_s1;
	logic signed [SW-1:0]    ext;

	always_ff @(posedge clk) begin
		prod_s1 <= (MW + EW)'(a) * (MW + EW)'(b);
		high_s1 <= ctrl.high;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1 <= 1'b0;
		end else begin
			en_s1 <= ctrl.en;
		end
	end

	assign ext = SW'(prod_s1);

	// The high half of an axis component carries a weight of two to the LW.
	always_ff @(posedge clk) begin
		if (ctrl.clr) begin
			acc_q <= '0;
		end else if (en_s1) begin
			acc_q <= acc_q + (high_s1 ? (ext <<< LW) : ext);
		end
	end

endmodule

### hdl/tpi_merge.sv
// Merging stage: spans of both triangles on the current axis and the overlap check.
// Depends on tpi_pkg for the lane count.
module tpi_merge #(
	parameter int W = tpi_pkg::COORD_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  load,
	input  logic signed [3*W+5:0] proj[tpi_pkg::NUM_VERT],
	output logic                  sep
);

	localparam int SW = 3 * W + 6;

	logic signed [SW-1:0] lo1_s1, hi1_s1, lo2_s1, hi2_s1;

	function automatic logic signed [SW-1:0] min3(input logic signed [SW-1:0] p,
		input logic signed [SW-1:0] q, input logic signed [SW-1:0] r);
		logic signed [SW-1:0] m;
		m = (q < p) ? q : p;
		return (r < m) ? r : m;
	endfunction

	function automatic logic signed [SW-1:0] max3(input logic signed [SW-1:0] p,
		input logic signed [SW-1:0] q, input logic signed [SW-1:0] r);
		logic signed [SW-1:0] m;
		m = (q > p) ? q : p;
		return (r > m) ? r : m;
	endfunction

	always_ff @(posedge clk) begin
		if (load) begin
			lo1_s1 <= min3(proj[0], proj[1], proj[2]);
			hi1_s1 <= max3(proj[0], proj[1], proj[2]);
			lo2_s1 <= min3(proj[3], proj[4], proj[5]);
			hi2_s1 <= max3(proj[3], proj[4], proj[5]);
		end
	end

	assign sep = (hi1_s1 < lo2_s1) || (hi2_s1 < lo1_s1);

endmodule

### hdl/triangle_pair_intersect_test.sv
// Top level of the triangle pair intersection test.
// Depends on tpi_pkg, tpi_axis_gen, tpi_proj_lane and tpi_merge.
//
// Usage: each request on the req channel carries one triangle (nine signed
// coordinates). A request with req_type at REQ_STORE keeps the triangle as the
// first of a pair and gives no response. A request with req_type at REQ_TEST
// is tested against the stored triangle and gives one response on the rsp
// channel: pierced, shares_vertex and boxes_overlap. A test before any store
// is dropped without a response. The stored triangle stays, so many tests may
// follow one store.
// Sequence: a test whose boxes miss or that shares a vertex goes from state
// IDLE straight to FIN, which loads the response registers. Otherwise six
// projection lanes (one per vertex) sweep up to eleven axes; each axis passes
// through MUL and SUB for the cross product, six multiplier passes in PROJ,
// DRAIN, and MINMAX and CMP for the merge, and the sweep ends at the first
// separating axis. req_stall is high while a test is in progress.
// Reset clears the stored-triangle flag and the response valid. A stalled
// response holds; the block finishes its next test and then waits for it.
module triangle_pair_intersect_test #(
	parameter int COORD_WIDTH = tpi_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic                          req_type,
	input  logic signed [COORD_WIDTH-1:0] ax,
	input  logic signed [COORD_WIDTH-1:0] ay,
	input  logic signed [COORD_WIDTH-1:0] az,
	input  logic signed [COORD_WIDTH-1:0] bx,
	input  logic signed [COORD_WIDTH-1:0] by_coord,
	input  logic signed [COORD_WIDTH-1:0] bz,
	input  logic signed [COORD_WIDTH-1:0] cx,
	input  logic signed [COORD_WIDTH-1:0] cy,
	input  logic signed [COORD_WIDTH-1:0] cz,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic                          pierced,
	output logic                          shares_vertex,
	output logic                          boxes_overlap
);

	localparam int W  = COORD_WIDTH;
	localparam int EW = W + 1;
	localparam int AW = 2 * W + 3;
	localparam int LW = (AW + 1) / 2;
	localparam int MW = LW + 1;
	localparam int SW = AW + EW + 2;

	tpi_pkg::state_t state_q, state_d;

	logic signed [W-1:0]  probe[3][3];
	logic signed [W-1:0]  t1_q[3][3];
	logic signed [W-1:0]  t2_q[3][3];
	logic signed [EW-1:0] rel_q[tpi_pkg::NUM_VERT][3];
	logic                 loaded_q;
	logic                 box_q, share_q, nosep_q;
	logic                 box_c, share_c;
	logic [tpi_pkg::AXIS_IDX_W-1:0] axis_idx_q;
	logic [2:0]           step_q;
	logic                 accept, start, fin_load, cmp_sep, cmp_last;
	logic                 rsp_valid_q, pierced_q, shares_q, overlap_q;

	tpi_pkg::gen_ctrl_t   gen_ctrl;
	tpi_pkg::lane_ctrl_t  lane_ctrl;
	logic                 merge_load;

	logic signed [AW-1:0] axis[3];
	logic                 axis_zero;
	logic [1:0]           comp;
	logic signed [MW-1:0] lane_a;
	logic signed [SW-1:0] proj[tpi_pkg::NUM_VERT];
	logic                 sep;

	assign probe[0][0] = ax;
	assign probe[0][1] = ay;
	assign probe[0][2] = az;
	assign probe[1][0] = bx;
	assign probe[1][1] = by_coord;
	assign probe[1][2] = bz;
	assign probe[2][0] = cx;
	assign probe[2][1] = cy;
	assign probe[2][2] = cz;

	assign accept = req_valid && !req_stall;
	assign start = accept && (req_type == tpi_pkg::REQ_TEST) && loaded_q;

	// Vertex sharing and bounding boxes come straight from the raw coordinates.
	always_comb begin
		logic signed [W-1:0] lo1, hi1, lo2, hi2;
		share_c = 1'b0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if ((t1_q[i][0] == probe[j][0]) && (t1_q[i][1] == probe[j][1]) &&
					(t1_q[i][2] == probe[j][2]))
					share_c = 1'b1;
			end
		end
		box_c = 1'b1;
		for (int k = 0; k < 3; k++) begin
			lo1 = t1_q[0][k];
			hi1 = t1_q[0][k];
			lo2 = probe[0][k];
			hi2 = probe[0][k];
			for (int v = 1; v < 3; v++) begin
				if (t1_q[v][k] < lo1) lo1 = t1_q[v][k];
				if (t1_q[v][k] > hi1) hi1 = t1_q[v][k];
				if (probe[v][k] < lo2) lo2 = probe[v][k];
				if (probe[v][k] > hi2) hi2 = probe[v][k];
			end
			if (!((lo1 <= hi2) && (hi1 >= lo2)))
				box_c = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= 1'b0;
		end else if (accept && (req_type == tpi_pkg::REQ_STORE)) begin
			loaded_q <= 1'b1;
		end
	end

	// Vertex coordinates relative to the first vertex of the stored triangle
	// shift every projection by the same amount, so the comparisons hold.
	always_ff @(posedge clk) begin
		if (accept && (req_type == tpi_pkg::REQ_STORE)) begin
			t1_q <= probe;
		end
		if (start) begin
			t2_q <= probe;
			share_q <= share_c;
			box_q <= box_c;
			for (int v = 0; v < 3; v++) begin
				for (int k = 0; k < 3; k++) begin
					rel_q[v][k]     <= EW'(t1_q[v][k]) - EW'(t1_q[0][k]);
					rel_q[v + 3][k] <= EW'(probe[v][k]) - EW'(t1_q[0][k]);
				end
			end
		end
	end

	assign cmp_sep = sep && !axis_zero;
	assign cmp_last = (axis_idx_q == tpi_pkg::AXIS_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tpi_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		req_stall = 1'b1;
		gen_ctrl = '0;
		lane_ctrl = '0;
		merge_load = 1'b0;
		fin_load = 1'b0;
		case (state_q)
			tpi_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				if (start)
					state_d = (box_c && !share_c) ? tpi_pkg::ST_MUL : tpi_pkg::ST_FIN;
			end
			tpi_pkg::ST_MUL: begin
				gen_ctrl.mul = 1'b1;
				state_d = tpi_pkg::ST_SUB;
			end
			tpi_pkg::ST_SUB: begin
				gen_ctrl.sub = 1'b1;
				lane_ctrl.clr = 1'b1;
				state_d = tpi_pkg::ST_PROJ;
			end
			tpi_pkg::ST_PROJ: begin
				lane_ctrl.en = 1'b1;
				lane_ctrl.high = step_q[0];
				if (step_q == tpi_pkg::STEP_LAST)
					state_d = tpi_pkg::ST_DRAIN;
			end
			tpi_pkg::ST_DRAIN: begin
				state_d = tpi_pkg::ST_MINMAX;
			end
			tpi_pkg::ST_MINMAX: begin
				merge_load = 1'b1;
				state_d = tpi_pkg::ST_CMP;
			end
			tpi_pkg::ST_CMP: begin
				state_d = (cmp_sep || cmp_last) ? tpi_pkg::ST_FIN : tpi_pkg::ST_MUL;
			end
			tpi_pkg::ST_FIN: begin
				if (!rsp_valid_q || !rsp_stall) begin
					fin_load = 1'b1;
					state_d = tpi_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tpi_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			axis_idx_q <= tpi_pkg::AXIS_N1;
			nosep_q <= 1'b0;
		end else begin
			if (state_q == tpi_pkg::ST_SUB)
				step_q <= '0;
			else if (state_q == tpi_pkg::ST_PROJ)
				step_q <= step_q + 3'd1;
			if (start) begin
				axis_idx_q <= tpi_pkg::AXIS_N1;
				nosep_q <= 1'b1;
			end else if (state_q == tpi_pkg::ST_CMP) begin
				if (cmp_sep)
					nosep_q <= 1'b0;
				else if (!cmp_last)
					axis_idx_q <= axis_idx_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fin_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			pierced_q <= box_q && !share_q && nosep_q;
			shares_q <= share_q;
			overlap_q <= box_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign pierced = pierced_q;
	assign shares_vertex = shares_q;
	assign boxes_overlap = overlap_q;

	tpi_axis_gen #(.W(W)) u_axis_gen (
		.clk    (clk),
		.ctrl   (gen_ctrl),
		.idx    (axis_idx_q),
		.t1     (t1_q),
		.t2     (t2_q),
		.axis_q (axis),
		.zero_q (axis_zero)
	);

	// Each multiplier pass takes the low or the high half of one axis component.
	assign comp = step_q[2:1];
	assign lane_a = step_q[0] ? MW'($signed(axis[comp][AW-1:LW]))
		: $signed({1'b0, axis[comp][LW-1:0]});

	for (genvar g = 0; g < tpi_pkg::NUM_VERT; g++) begin : g_lane
		tpi_proj_lane #(.W(W)) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (lane_ctrl),
			.a      (lane_a),
			.b      (rel_q[g][comp]),
			.acc_q  (proj[g])
		);
	end

	tpi_merge #(.W(W)) u_merge (
		.clk  (clk),
		.load (merge_load),
		.proj (proj),
		.sep  (sep)
	);

`ifndef SYNTH
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (!pierced || (boxes_overlap && !shares_vertex)))
		else $error("pierced response without box overlap or with a shared vertex");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tpi_pkg::ST_PROJ) |-> (step_q <= tpi_pkg::STEP_LAST))
		else $error("projection step counter ran past its last pass");

	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req_type == tpi_pkg::REQ_TEST) && !loaded_q)
		|=> (state_q == tpi_pkg::ST_IDLE))
		else $error("test request before any store started a sweep");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tpi_pkg::ST_MUL)
		|-> ((axis_idx_q <= tpi_pkg::AXIS_LAST) && box_q && !share_q))
		else $error("axis sweep running with a bad index or a decided result");
`endif

endmodule

### dv/triangle_pair_intersect_test_tb.sv
// Self-checking testbench for triangle_pair_intersect_test: store and test requests with
// random handshake gaps, each response checked against an exact integer predictor or a fixed verdict.
// Depends on tpi_pkg and the triangle_pair_intersect_test RTL.
module triangle_pair_intersect_test_tb;

	localparam int CW = tpi_pkg::COORD_WIDTH_DEF;
	localparam longint CMAX = 64'sd8388607;
	localparam longint CMIN = -64'sd8388608;
	localparam int N_RANDOM = 1100;
	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 150;

	typedef logic signed [127:0] wide_t;
	typedef longint coords_t[9];
	typedef wide_t vec_t[3];

	typedef struct {
		logic    kind;
		coords_t c;
		bit      typed;
		bit      e_pierced, e_shared, e_overlap;
	} request_t;

	typedef struct {
		bit pierced, shared, overlap;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_type = tpi_pkg::REQ_STORE;
	logic signed [CW-1:0] ax = '0, ay = '0, az = '0, bx = '0, by_coord = '0, bz = '0;
	logic signed [CW-1:0] cx = '0, cy = '0, cz = '0;
	logic rsp_stall = 1'b0;
	logic req_stall, rsp_valid, pierced, shares_vertex, boxes_overlap;

	triangle_pair_intersect_test dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
		.ax(ax), .ay(ay), .az(az), .bx(bx), .by_coord(by_coord), .bz(bz),
		.cx(cx), .cy(cy), .cz(cz),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.pierced(pierced), .shares_vertex(shares_vertex), .boxes_overlap(boxes_overlap)
	);

	always #10 clk = ~clk;

	request_t stim[$];
	verdict_t expected_verdicts[$];
	coords_t first_tri;
	bit first_loaded = 0;
	int idx = 0;
	bit taken = 0;
	int errs = 0;
	int idle_cycles = 0;
	int n_store = 0, n_test = 0, n_rsp = 0, n_pierced = 0, n_shared = 0;

	function automatic longint wrap(longint v);
		logic [CW-1:0] b;
		b = v[CW-1:0];
		return longint'($signed(b));
	endfunction

	function automatic void cross3(longint u[3], longint v[3], output vec_t r);
		for (int k = 0; k < 3; k++)
			r[k] = wide_t'(u[(k+1)%3]) * wide_t'(v[(k+2)%3])
				- wide_t'(u[(k+2)%3]) * wide_t'(v[(k+1)%3]);
	endfunction

	function automatic void side(coords_t t, int from, int to, output longint r[3]);
		for (int k = 0; k < 3; k++)
			r[k] = t[to*3+k] - t[from*3+k];
	endfunction

	function automatic void project(coords_t t, vec_t a, output wide_t lo, output wide_t hi);
		wide_t s;
		lo = 0;
		hi = 0;
		for (int v = 0; v < 3; v++) begin
			s = 0;
			for (int k = 0; k < 3; k++)
				s = s + a[k] * wide_t'(t[v*3+k]);
			if (v == 0 || s < lo)
				lo = s;
			if (v == 0 || s > hi)
				hi = s;
		end
	endfunction

	function automatic bit axis_separates(coords_t t1, coords_t t2, vec_t a);
		wide_t lo1, hi1, lo2, hi2;
		if (a[0] == 0 && a[1] == 0 && a[2] == 0)
			return 0;
		project(t1, a, lo1, hi1);
		project(t2, a, lo2, hi2);
		return hi1 < lo2 || hi2 < lo1;
	endfunction

	function automatic bit any_separating_axis(coords_t t1, coords_t t2);
		longint u[3], v[3];
		vec_t a;
		side(t1, 0, 1, u);
		side(t1, 0, 2, v);
		cross3(u, v, a);
		if (axis_separates(t1, t2, a))
			return 1;
		side(t2, 0, 1, u);
		side(t2, 0, 2, v);
		cross3(u, v, a);
		if (axis_separates(t1, t2, a))
			return 1;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				side(t1, i, (i+1)%3, u);
				side(t2, j, (j+1)%3, v);
				cross3(u, v, a);
				if (axis_separates(t1, t2, a))
					return 1;
			end
		return 0;
	endfunction

	function automatic verdict_t predict_pair(coords_t t1, coords_t t2);
		verdict_t r;
		longint lo1, hi1, lo2, hi2;
		r.shared = 0;
		r.overlap = 1;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				if (t1[i*3] == t2[j*3] && t1[i*3+1] == t2[j*3+1] && t1[i*3+2] == t2[j*3+2])
					r.shared = 1;
		for (int k = 0; k < 3; k++) begin
			lo1 = t1[k]; hi1 = t1[k]; lo2 = t2[k]; hi2 = t2[k];
			for (int v = 1; v < 3; v++) begin
				if (t1[v*3+k] < lo1) lo1 = t1[v*3+k];
				if (t1[v*3+k] > hi1) hi1 = t1[v*3+k];
				if (t2[v*3+k] < lo2) lo2 = t2[v*3+k];
				if (t2[v*3+k] > hi2) hi2 = t2[v*3+k];
			end
			if (!(lo1 <= hi2 && hi1 >= lo2))
				r.overlap = 0;
		end
		r.pierced = r.overlap && !r.shared && !any_separating_axis(t1, t2);
		return r;
	endfunction

	task automatic add_row(logic kind, coords_t c, bit typed = 0,
			bit p = 0, bit s = 0, bit o = 0);
		request_t r;
		r.kind = kind;
		for (int i = 0; i < 9; i++)
			r.c[i] = wrap(c[i]);
		r.typed = typed;
		r.e_pierced = p;
		r.e_shared = s;
		r.e_overlap = o;
		stim.insert(stim.size(), r);
	endtask

	// Random triangles cluster around a center so that boxes meet and
	// triangles pierce often; the widest spread covers every coordinate bit.
	task automatic add_random_rows();
		coords_t t, last;
		longint center[3];
		longint spread;
		int k, v;
		last = '{0, 0, 0, 4096, 0, 0, 0, 4096, 0};
		for (int n = 0; n < N_RANDOM; n++) begin
			k = $urandom_range(23, 2);
			spread = 64'sd1 << k;
			if ($urandom_range(9) == 0) begin
				for (int i = 0; i < 9; i++)
					t[i] = longint'($signed(24'($urandom)));
			end else begin
				v = $urandom_range(2);
				for (int i = 0; i < 3; i++)
					center[i] = last[v*3+i];
				for (int i = 0; i < 9; i++)
					t[i] = center[i%3] + longint'($urandom_range(2*spread, 0)) - spread;
				if ($urandom_range(9) == 0) begin
					v = $urandom_range(2);
					k = $urandom_range(2);
					for (int i = 0; i < 3; i++)
						t[v*3+i] = last[k*3+i];
				end
			end
			if ($urandom_range(3) == 0) begin
				add_row(tpi_pkg::REQ_STORE, t);
				last = stim[$].c;
			end else begin
				add_row(tpi_pkg::REQ_TEST, t);
			end
		end
	endtask

	function automatic int send_idle_pct();
		if (idx < stim.size() / 3)
			return 9;
		else if (idx < 2 * stim.size() / 3)
			return 48;
		return 0;
	endfunction

	function automatic int recv_stall_pct();
		if (idx < stim.size() / 3)
			return 48;
		else if (idx < 2 * stim.size() / 3)
			return 9;
		return 0;
	endfunction

	// Drive at the falling edge; a stalled request holds its payload.
	always @(negedge clk) begin
		if (taken) begin
			taken = 0;
			idx++;
			req_valid = 1'b0;
		end
		if (arst_n && !(req_valid && req_stall)) begin
			if (idx < stim.size() && $urandom_range(99) >= send_idle_pct()) begin
				req_valid = 1'b1;
				req_type = stim[idx].kind;
				{ax, ay, az} = {stim[idx].c[0][CW-1:0], stim[idx].c[1][CW-1:0],
					stim[idx].c[2][CW-1:0]};
				{bx, by_coord, bz} = {stim[idx].c[3][CW-1:0], stim[idx].c[4][CW-1:0],
					stim[idx].c[5][CW-1:0]};
				{cx, cy, cz} = {stim[idx].c[6][CW-1:0], stim[idx].c[7][CW-1:0],
					stim[idx].c[8][CW-1:0]};
			end else begin
				req_valid = 1'b0;
			end
		end
		rsp_stall = arst_n && ($urandom_range(99) < recv_stall_pct());
	end

	always @(posedge clk) begin
		verdict_t e;
		bit moved;
		moved = 0;
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				moved = 1;
				taken = 1;
				if (stim[idx].kind == tpi_pkg::REQ_STORE) begin
					first_tri = stim[idx].c;
					first_loaded = 1;
					n_store++;
				end else if (first_loaded) begin
					n_test++;
					if (stim[idx].typed) begin
						e.pierced = stim[idx].e_pierced;
						e.shared = stim[idx].e_shared;
						e.overlap = stim[idx].e_overlap;
					end else begin
						e = predict_pair(first_tri, stim[idx].c);
					end
					expected_verdicts.insert(expected_verdicts.size(), e);
				end
			end
			if (rsp_valid && !rsp_stall) begin
				moved = 1;
				n_rsp++;
				if (expected_verdicts.size() == 0) begin
					$error("response with no test outstanding");
					errs++;
				end else begin
					e = expected_verdicts.pop_front();
					n_pierced += pierced;
					n_shared += shares_vertex;
					if (pierced !== e.pierced) begin
						$error("pierced: expected %0b, got %0b", e.pierced, pierced);
						errs++;
					end
					if (shares_vertex !== e.shared) begin
						$error("shares_vertex: expected %0b, got %0b", e.shared, shares_vertex);
						errs++;
					end
					if (boxes_overlap !== e.overlap) begin
						$error("boxes_overlap: expected %0b, got %0b", e.overlap, boxes_overlap);
						errs++;
					end
				end
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("triangle_pair_intersect_test_tb: errors");
				$finish;
			end
		end
	end

	initial begin
		// A test with nothing stored is dropped without a response.
		add_row(tpi_pkg::REQ_TEST, '{0, 0, 0, 4096, 0, 0, 0, 4096, 0});
		add_row(tpi_pkg::REQ_STORE, '{0, 0, 0, 4096, 0, 0, 0, 4096, 0});
		add_row(tpi_pkg::REQ_TEST, '{0, 0, 0, 4096, 0, 0, 0, 4096, 0}, 1, 0, 1, 1);
		add_row(tpi_pkg::REQ_TEST, '{2000000, 0, 0, 2004096, 0, 0, 2000000, 4096, 0},
			1, 0, 0, 0);
		add_row(tpi_pkg::REQ_TEST, '{0, 0, 100, 4096, 0, 100, 0, 4096, 100}, 1, 0, 0, 0);
		add_row(tpi_pkg::REQ_TEST, '{1000, 1000, -2000, 1000, 1000, 2000, 1200, 900, 0});
		add_row(tpi_pkg::REQ_TEST, '{1000, 1000, 1, 1000, 1000, 2000, 1200, 900, 500});
		// Coplanar overlap and a translated copy, whose parallel edges give zero axes.
		add_row(tpi_pkg::REQ_TEST, '{1000, 1000, 0, 5000, 1000, 0, 1000, 5000, 0});
		add_row(tpi_pkg::REQ_TEST, '{1, 1, 0, 4097, 1, 0, 1, 4097, 0});
		add_row(tpi_pkg::REQ_TEST, '{0, 0, 0, 50, 60, 1, -30, 70, -1}, 1, 0, 1, 1);
		add_row(tpi_pkg::REQ_STORE, '{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, 0});
		add_row(tpi_pkg::REQ_TEST, '{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN});
		add_row(tpi_pkg::REQ_TEST, '{CMAX, CMAX, CMAX, -1, -1, -1, 0, 0, 0}, 1, 0, 1, 1);
		add_row(tpi_pkg::REQ_TEST, '{0, 0, -100, 1, 1, 100, -1, 1, 0});
		add_row(tpi_pkg::REQ_TEST, '{CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMIN, CMIN});
		// Degenerate stored triangle: all three vertices at one point.
		add_row(tpi_pkg::REQ_STORE, '{77, -77, 5, 77, -77, 5, 77, -77, 5});
		add_row(tpi_pkg::REQ_TEST, '{0, -100, 0, 200, -100, 0, 0, 100, 10});
		add_row(tpi_pkg::REQ_TEST, '{77, -77, 5, 1, 2, 3, 4, 5, 6}, 1, 0, 1, 1);
		add_row(tpi_pkg::REQ_TEST, '{1000, 1000, 1000, 2000, 1000, 1000, 1000, 2000, 1000},
			1, 0, 0, 0);
		add_row(tpi_pkg::REQ_STORE, '{-4096, -4096, 0, 4096, -4096, 0, 0, 4096, 0});
		add_row(tpi_pkg::REQ_TEST, '{0, 0, -4096, 0, 0, 4096, 0, -8192, 0});
		add_random_rows();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (idx == stim.size() && expected_verdicts.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Covered %0d stores and %0d tests; %0d responses,", n_store, n_test, n_rsp);
		$display("%0d of them pierced and %0d shared a vertex.", n_pierced, n_shared);
		if (errs == 0 && expected_verdicts.size() == 0)
			$display("triangle_pair_intersect_test_tb: clean");
		else
			$display("triangle_pair_intersect_test_tb: errors");
		$finish;
	end

endmodule

### sim.f
hdl/tpi_pkg.sv
hdl/tpi_axis_gen.sv
hdl/tpi_proj_lane.sv
hdl/tpi_merge.sv
hdl/triangle_pair_intersect_test.sv
dv/triangle_pair_intersect_test_tb.sv
